/* design/fc_pkg.sv */
// fc_pkg: shared types and constants for the fir_convolution block
// transaction payload structs, command codes, controller states, mac control
// no dependencies
`timescale 1ns / 1ps

package fc_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 38;
  localparam int CFG_BITS    = 7;
  localparam int INDEX_BITS  = 6;

  // product and sign-extension widths of the mac
  localparam int PROD_BITS = 2 * SAMPLE_BITS;
  localparam int EXT_BITS  = (OUT_BITS > PROD_BITS) ? OUT_BITS : PROD_BITS;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [INDEX_BITS-1:0]         tap_index;
    logic signed [SAMPLE_BITS-1:0] coef_value;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } fc_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] filtered;
    logic                       last_result;
  } fc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_WAIT,
    S_EMIT,
    S_SHIFT
  } fc_state_e;

  // control from the sequencer to the mac datapath
  typedef struct packed {
    logic clear;
    logic issue;
    logic last;
  } mac_ctrl_t;

endpackage

/* design/fc_ram.sv */
// fc_ram: generic single-write, single-read synchronous ram
// read data is registered; no dependencies
`timescale 1ns / 1ps

module fc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fc_mac.sv */
// fc_mac: shared multiply-accumulate datapath of the fir_convolution block
// aligns control with the ram read latency, registers the product, accumulates
// depends on fc_pkg
`timescale 1ns / 1ps

module fc_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fc_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [fc_pkg::SAMPLE_BITS-1:0] coef_i,
  input  logic signed [fc_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic signed [fc_pkg::OUT_BITS-1:0]    acc_o,
  output logic                                  done_o
);

  import fc_pkg::*;

  logic                        rd_v_q, rd_last_q;
  logic                        prod_v_q, prod_last_q;
  logic                        done_q;
  logic signed [PROD_BITS-1:0] prod_d, prod_q;
  logic signed [EXT_BITS-1:0]  prod_ext;
  logic signed [OUT_BITS-1:0]  acc_d, acc_q;

  // product of the ram outputs, then sign-extend and wrap to output width
  assign prod_d   = PROD_BITS'(coef_i) * PROD_BITS'(sample_i);
  assign prod_ext = EXT_BITS'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + prod_ext[OUT_BITS-1:0];
    end
  end

  // pipeline control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      rd_v_q      <= ctrl_i.issue;
      rd_last_q   <= ctrl_i.issue & ctrl_i.last;
      prod_v_q    <= rd_v_q;
      prod_last_q <= rd_last_q;
      done_q      <= prod_v_q & prod_last_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

/* design/fir_convolution.sv */
// fir_convolution: top level, sequencer, delay-line pointer and valid bits
// depends on fc_pkg, fc_ram, fc_mac
`timescale 1ns / 1ps

// Streaming direct-form FIR that produces the full linear convolution of a
// sample sequence with up to MAX_TAPS coefficients. Coefficients and the delay
// line each live in a synchronous ram with one read port; the delay line is a
// circular buffer with one valid bit per entry, so it reads as zero after
// reset and after each sequence without a clearing pass. One shared multiplier
// walks the M taps one per cycle (M = tap_count, zero reading as one, larger
// values saturating at MAX_TAPS). Each output writes its sample, issues the M
// tap reads, passes the ram read, product and accumulator registers, and then
// hands the result to the output register. A sample marked last is followed by
// M - 1 tail outputs. A coefficient load gives no result. The input stalls
// while an output is being computed; a finished result can wait in the output
// register while the next transaction is accepted.

module fir_convolution #(
  parameter int MAX_TAPS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fc_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fc_pkg::fc_in_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fc_pkg::fc_out_t              out_data_o
);

  import fc_pkg::*;

  localparam int IDX_W = $clog2(MAX_TAPS);

  fc_state_e state_q, state_d;

  logic [CFG_BITS-1:0] tap_count_q;
  logic [CFG_BITS-1:0] taps;
  logic [IDX_W-1:0]    taps_m1;
  logic [IDX_W-1:0]    head_q, head_dec;
  logic [IDX_W-1:0]    j_q;
  logic [IDX_W:0]      addr_sum;
  logic [IDX_W-1:0]    dl_raddr;
  logic [MAX_TAPS-1:0] dl_valid_q;
  logic                dv_q;
  logic                seq_last_q;
  logic [CFG_BITS-1:0] tail_q;
  logic                out_valid_q;
  fc_out_t             out_data_q;

  logic                    accept, acc_sample, acc_load;
  logic                    start_shift, emit, final_out, out_free, j_last;
  logic                    coef_we;
  logic [SAMPLE_BITS-1:0]  dl_wdata;
  logic [SAMPLE_BITS-1:0]  coef_rdata, dl_rdata;
  logic signed [SAMPLE_BITS-1:0] dl_sample;
  logic signed [OUT_BITS-1:0]    acc;
  logic                    mac_done;
  mac_ctrl_t               mac_ctrl;

  // taps in use: zero reads as one, large values saturate
  always_comb begin
    if (tap_count_q == '0) begin
      taps = CFG_BITS'(1);
    end else if (tap_count_q > CFG_BITS'(MAX_TAPS)) begin
      taps = CFG_BITS'(MAX_TAPS);
    end else begin
      taps = tap_count_q;
    end
  end
  assign taps_m1 = IDX_W'(taps - CFG_BITS'(1));

  // circular buffer addressing
  assign head_dec = (head_q == '0) ? IDX_W'(MAX_TAPS - 1) : head_q - IDX_W'(1);
  assign addr_sum = {1'b0, head_q} + {1'b0, j_q};
  assign dl_raddr = (addr_sum >= (IDX_W + 1)'(MAX_TAPS)) ?
                    IDX_W'(addr_sum - (IDX_W + 1)'(MAX_TAPS)) : addr_sum[IDX_W-1:0];

  // handshake terms
  assign accept     = in_valid_i & ~in_stall_o;
  assign acc_sample = accept & (in_data_i.command == CMD_SAMPLE);
  assign acc_load   = accept & (in_data_i.command == CMD_LOAD);
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign j_last     = (j_q == taps_m1);
  assign final_out  = seq_last_q & (tail_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc_sample) state_d = S_MAC;
      end
      S_MAC: begin
        if (j_last) state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mac_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = (seq_last_q && !final_out) ? S_SHIFT : S_IDLE;
        end
      end
      S_SHIFT: state_d = S_MAC;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o     = 1'b1;
    start_shift    = 1'b0;
    emit           = 1'b0;
    coef_we        = 1'b0;
    dl_wdata       = '0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.last  = j_last;
    case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        start_shift = acc_sample;
        dl_wdata    = in_data_i.sample;
        coef_we     = acc_load &&
                      ({1'b0, in_data_i.tap_index} < (INDEX_BITS + 1)'(MAX_TAPS));
      end
      S_MAC: mac_ctrl.issue = 1'b1;
      S_WAIT: ;
      S_EMIT: emit = out_free;
      S_SHIFT: start_shift = 1'b1;
      default: ;
    endcase
    mac_ctrl.clear = start_shift;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_count_q <= CFG_BITS'(1);
      head_q      <= '0;
      j_q         <= '0;
      dl_valid_q  <= '0;
      dv_q        <= 1'b0;
      seq_last_q  <= 1'b0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= dl_valid_q[dl_raddr];
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
      // new sample or zero shifted into the delay line
      if (start_shift) begin
        head_q               <= head_dec;
        dl_valid_q[head_dec] <= 1'b1;
        j_q                  <= '0;
      end else if (mac_ctrl.issue) begin
        j_q <= j_q + IDX_W'(1);
      end
      if (acc_sample) begin
        seq_last_q <= in_data_i.last_sample;
        tail_q     <= in_data_i.last_sample ? taps - CFG_BITS'(1) : '0;
      end
      // end of sequence clears the delay line, otherwise count the tail
      if (emit) begin
        if (final_out) begin
          dl_valid_q <= '0;
          seq_last_q <= 1'b0;
        end else if (seq_last_q) begin
          tail_q <= tail_q - CFG_BITS'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.filtered    <= acc;
      out_data_q.last_result <= final_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // coefficient store
  fc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (in_data_i.tap_index[IDX_W-1:0]),
    .wdata_i (in_data_i.coef_value),
    .raddr_i (j_q),
    .rdata_o (coef_rdata)
  );

  // delay line store
  fc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (start_shift),
    .waddr_i (head_dec),
    .wdata_i (dl_wdata),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

  // entries not written since the last clear read as zero
  assign dl_sample = dv_q ? dl_rdata : '0;

  fc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_rdata),
    .sample_i (dl_sample),
    .acc_o    (acc),
    .done_o   (mac_done)
  );

endmodule

/* dv/tb_fir_convolution.sv */
// tb_fir_convolution: self-checking testbench for the streaming fir convolution block
// predicts every output from its own tap and delay-line copy, checks in order
// depends on fc_pkg and fir_convolution
`timescale 1ns / 1ps

module tb_fir_convolution;
  import fc_pkg::*;

  localparam int MAX_TAPS     = 64;
  // drain wait covers the longest output, at MAX_TAPS taps, plus margin
  localparam int DRAIN_CYCLES = MAX_TAPS + 16;
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int RANDOM_ITEMS = 175;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_BITS-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  fc_in_t              in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  fc_out_t             out_data_o;

  // predictor state: coefficients, sample history and tap count register
  logic signed [SAMPLE_BITS-1:0] coef_mem    [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] sample_hist [MAX_TAPS];
  logic [CFG_BITS-1:0]           tap_reg;

  // convolution outputs still awaited, oldest first
  fc_out_t conv_outputs_q [$];

  int err_cnt   = 0;
  int cycle_cnt = 0;
  int out_hold  = 0;
  bit no_idle   = 1'b0;

  fir_convolution #(
    .MAX_TAPS(MAX_TAPS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero selects one tap, anything above the maximum saturates
  function automatic int taps_active();
    if (tap_reg == '0) return 1;
    if (tap_reg > MAX_TAPS) return MAX_TAPS;
    return int'(tap_reg);
  endfunction

  // exact sum of products, wrapped to the output width
  function automatic logic signed [OUT_BITS-1:0] tap_sum(input int taps);
    longint acc;
    acc = 0;
    for (int j = 0; j < taps; j++)
      acc += longint'(coef_mem[j]) * longint'(sample_hist[j]);
    return acc[OUT_BITS-1:0];
  endfunction

  task automatic shift_sample(input logic signed [SAMPLE_BITS-1:0] s);
    for (int i = MAX_TAPS - 1; i > 0; i--)
      sample_hist[i] = sample_hist[i-1];
    sample_hist[0] = s;
  endtask

  // update predictor state for one accepted transaction, queue its outputs
  task automatic convolve_step(input fc_in_t item);
    int      taps;
    fc_out_t res;
    taps = taps_active();
    if (item.command == CMD_LOAD) begin
      coef_mem[item.tap_index] = item.coef_value;
    end else begin
      shift_sample(item.sample);
      res.filtered    = tap_sum(taps);
      res.last_result = item.last_sample && (taps == 1);
      conv_outputs_q.push_back(res);
      if (item.last_sample) begin
        // tail outputs with zeros shifted in, then the history clears
        for (int t = 1; t < taps; t++) begin
          shift_sample('0);
          res.filtered    = tap_sum(taps);
          res.last_result = (t == taps - 1);
          conv_outputs_q.push_back(res);
        end
        for (int i = 0; i < MAX_TAPS; i++) sample_hist[i] = '0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------

  function automatic fc_in_t make_load(input logic [INDEX_BITS-1:0] idx,
                                       input logic signed [SAMPLE_BITS-1:0] c,
                                       input logic last);
    fc_in_t item;
    item.command     = CMD_LOAD;
    item.tap_index   = idx;
    item.coef_value  = c;
    item.sample      = SAMPLE_BITS'($urandom);
    item.last_sample = last;
    return item;
  endfunction

  function automatic fc_in_t make_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                         input logic last);
    fc_in_t item;
    item.command     = CMD_SAMPLE;
    item.tap_index   = INDEX_BITS'($urandom);
    item.coef_value  = SAMPLE_BITS'($urandom);
    item.sample      = s;
    item.last_sample = last;
    return item;
  endfunction

  // random sample with the full-scale values mixed in
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input transaction; valid stays high when the next one follows at once
  task automatic send_item(input fc_in_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    convolve_step(item);
  endtask

  // hold off input until every awaited output is back and the block is quiet
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (conv_outputs_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_BITS-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tap_reg   = value;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // single tap after reset: the final sample flags its own output,
  // a load ignores its last bit
  task automatic test_single_tap();
    send_item(make_load(6'd0, 16'h8000, 1'b1));
    send_item(make_sample(16'h8000, 1'b0));
    send_item(make_sample(16'h7fff, 1'b0));
    send_item(make_sample(16'h0000, 1'b1));
    send_item(make_load(6'd0, 16'h7fff, 1'b0));
    send_item(make_sample(16'h8000, 1'b1));
  endtask

  // write every coefficient so no tap count reads an unwritten entry
  task automatic test_coef_fill();
    logic signed [SAMPLE_BITS-1:0] c;
    for (int i = 0; i < MAX_TAPS; i++) begin
      if (i < 2)                 c = 16'h8000;
      else if (i == MAX_TAPS - 1) c = 16'h7fff;
      else                       c = SAMPLE_BITS'($urandom);
      send_item(make_load(INDEX_BITS'(i), c, 1'($urandom)));
    end
  endtask

  // largest products, tap count zero, saturation above maximum, maximum
  task automatic test_tap_limits();
    wait_drain();
    cfg_write(7'd2);
    send_item(make_sample(16'h8000, 1'b0));
    send_item(make_sample(16'h8000, 1'b1));
    wait_drain();
    cfg_write(7'd0);
    send_item(make_sample(16'h3039, 1'b1));
    wait_drain();
    cfg_write(7'd127);
    send_item(make_sample(16'h7fff, 1'b0));
    send_item(make_sample(16'h8000, 1'b0));
    send_item(make_sample(pick_sample(), 1'b1));
    wait_drain();
    cfg_write(7'(MAX_TAPS));
    send_item(make_sample(16'h7fff, 1'b1));
  endtask

  // tap count changes while a sequence is open
  task automatic test_taps_mid_sequence();
    wait_drain();
    cfg_write(7'd3);
    for (int k = 0; k < 5; k++) send_item(make_sample(pick_sample(), 1'b0));
    wait_drain();
    cfg_write(7'd10);
    for (int k = 0; k < 3; k++) send_item(make_sample(pick_sample(), k == 2));
  endtask

  // random sequences, mostly short filters, with loads and open sequences
  task automatic test_random_traffic();
    int sent;
    int seq_len;
    int taps_sel;
    bit closes;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drain();
      case ($urandom_range(0, 9))
        0:       taps_sel = 0;
        1:       taps_sel = 127;
        2:       taps_sel = $urandom_range(9, MAX_TAPS);
        default: taps_sel = $urandom_range(1, 8);
      endcase
      cfg_write(CFG_BITS'(taps_sel));
      no_idle = ($urandom_range(0, 3) == 0);
      seq_len = $urandom_range(1, 10);
      closes  = ($urandom_range(0, 4) != 0);
      for (int k = 0; k < seq_len; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(make_load(INDEX_BITS'($urandom), SAMPLE_BITS'($urandom),
                              1'($urandom)));
          sent++;
        end
        if ($urandom_range(0, 15) == 0) wait_drain();
        send_item(make_sample(pick_sample(), closes && (k == seq_len - 1)));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // output checker and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_outputs
    fc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (conv_outputs_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected output, expected none, actual filtered %0d last %0b",
                 $time, out_data_o.filtered, out_data_o.last_result);
      end else begin
        want = conv_outputs_q.pop_front();
        if (out_data_o.filtered !== want.filtered) begin
          err_cnt++;
          $display("%0t: filtered mismatch, expected %0d actual %0d",
                   $time, want.filtered, out_data_o.filtered);
        end
        if (out_data_o.last_result !== want.last_result) begin
          err_cnt++;
          $display("%0t: last_result mismatch, expected %0b actual %0b",
                   $time, want.last_result, out_data_o.last_result);
        end
      end
      out_hold = no_idle ? 0 : $urandom_range(0, 16);
    end else if (out_valid_o && out_hold > 0) begin
      out_hold--;
    end
    out_stall_i <= (out_hold > 0);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    tap_reg     = 7'd1;
    for (int i = 0; i < MAX_TAPS; i++) begin
      coef_mem[i]    = '0;
      sample_hist[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_tap();
    test_coef_fill();
    test_tap_limits();
    test_taps_mid_sequence();
    test_random_traffic();
    wait_drain();

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/fc_pkg.sv
design/fc_ram.sv
design/fc_mac.sv
design/fir_convolution.sv
dv/tb_fir_convolution.sv
